/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the linear move planner.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property must never hold.
`define ASSERT_NEVER(lbl, prop, msg) \
  `ASSERT_ALWAYS(lbl, !(prop), msg)

`endif

/* sv/lmp_pkg.sv */
// Package for the linear move planner: widths, codes, item and result types.
// No dependencies.
`default_nettype none
package lmp_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned CNT_W  = 24;
  localparam int unsigned SPM_W  = 16;
  localparam int unsigned RATE_W = 20;
  localparam int unsigned FEED_W = 24;
  localparam int unsigned P_W    = SPM_W + FEED_W;
  localparam int unsigned SQ_W   = 2 * CNT_W;
  localparam int unsigned S_W    = SQ_W + 1;
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned PH_W   = P_W / 2;
  localparam int unsigned PP_W   = CNT_W + PH_W;
  localparam int unsigned NP_W   = CNT_W + P_W;
  localparam int unsigned NUM_W  = NP_W + 1;
  localparam int unsigned QB     = RATE_W + 1;
  localparam int unsigned DIV_W  = ROOT_W + 2;
  localparam int unsigned FLR_W  = CNT_W + 10;
  localparam int unsigned CFG_W  = RATE_W;

  localparam logic [SPM_W-1:0]  SPM_RST      = 16'd100;
  localparam logic [RATE_W-1:0] MAX_RATE_RST = 20'd20000;
  localparam logic [9:0]        MS_PER_S     = 10'd1000;

  localparam logic CFG_SPM      = 1'b0;
  localparam logic CFG_MAX_RATE = 1'b1;

  typedef enum logic [1:0] {
    ST_PLANNED   = 2'd0,
    ST_BUSY      = 2'd1,
    ST_NO_MOTION = 2'd2
  } lmp_status_e;

  typedef struct packed {
    lmp_status_e      status;
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;
    logic             dir_x;
    logic             dir_y;
    logic [P_W-1:0]   p;
  } lmp_item_t;

  typedef struct packed {
    lmp_status_e       status;
    logic [CNT_W-1:0]  x_steps;
    logic [CNT_W-1:0]  y_steps;
    logic              dir_x;
    logic              dir_y;
    logic [RATE_W-1:0] x_rate;
    logic [RATE_W-1:0] y_rate;
  } lmp_res_t;

endpackage
`default_nettype wire

/* sv/two_axis_linear_move_planner_core.sv */
// A two-entry queue decouples front end and back end (32-stage root, 21-stage divider).
// Throughput: one beat per cycle while the output is not stalled.
// Reset: asynchronous active low; clears valids, step scale to 100, max_step_rate to 20000.
// Depends on lmp_pkg, lmp_front, lmp_fifo and lmp_back.
`default_nettype none
module two_axis_linear_move_planner_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [lmp_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [119:0]              s_axis_tdata,  // target_x, target_y, current_x, current_y, feed
  input  wire logic                      s_axis_tuser,  // motors_busy
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [95:0]                    m_axis_tdata,  // x_steps, y_steps, dir_x, dir_y, x_rate, y_rate, pad
  output logic [1:0]                     m_axis_tuser   // status
);

  logic [lmp_pkg::SPM_W-1:0]  spm_q;
  logic [lmp_pkg::RATE_W-1:0] max_rate_q;
  logic                       f_valid, f_ready, b_valid, b_ready;
  lmp_pkg::lmp_item_t         f_item, b_item;
  lmp_pkg::lmp_res_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_q      <= lmp_pkg::SPM_RST;
      max_rate_q <= lmp_pkg::MAX_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lmp_pkg::CFG_SPM:      spm_q      <= cfg_data_i[lmp_pkg::SPM_W-1:0];
        lmp_pkg::CFG_MAX_RATE: max_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lmp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .tx_i        (s_axis_tdata[23:0]),
    .ty_i        (s_axis_tdata[47:24]),
    .cx_i        (s_axis_tdata[71:48]),
    .cy_i        (s_axis_tdata[95:72]),
    .feed_i      (s_axis_tdata[119:96]),
    .busy_i      (s_axis_tuser),
    .spm_i       (spm_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  lmp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_item_i   (f_item),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_item_o  (b_item)
  );

  lmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_item_i   (b_item),
    .max_rate_i  (max_rate_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {6'd0, res.y_rate, res.x_rate, res.dir_y, res.dir_x,
                         res.y_steps, res.x_steps};
  assign m_axis_tuser = res.status;

endmodule
`default_nettype wire

/* sv/lmp_front.sv */
// Front end: deltas, step counts, directions, feed product and classification.
// Depends on lmp_pkg.
`default_nettype none
module lmp_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [lmp_pkg::POS_W-1:0]  tx_i,
  input  wire logic [lmp_pkg::POS_W-1:0]  ty_i,
  input  wire logic [lmp_pkg::POS_W-1:0]  cx_i,
  input  wire logic [lmp_pkg::POS_W-1:0]  cy_i,
  input  wire logic [lmp_pkg::FEED_W-1:0] feed_i,
  input  wire logic                       busy_i,
  input  wire logic [lmp_pkg::SPM_W-1:0]  spm_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output lmp_pkg::lmp_item_t              out_item_o
);

  localparam int unsigned MAG_W = lmp_pkg::POS_W + 1;
  localparam int unsigned PR_W  = MAG_W + lmp_pkg::SPM_W;
  localparam int unsigned NF_W  = PR_W - 8;

  logic                       va_q, vb_q;
  logic [MAG_W-1:0]           magx_q, magy_q;
  logic                       negx_q, negy_q, busy_q;
  logic [lmp_pkg::FEED_W-1:0] feed_q;
  lmp_pkg::lmp_item_t         item_q, item_d;
  logic                       en_a, en_b;
  logic signed [MAG_W-1:0]    dx, dy;
  logic [PR_W-1:0]            rx, ry;
  logic [NF_W-1:0]            nfx, nfy;
  logic                       zx, zy;

  assign en_b       = !vb_q || out_ready_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  assign dx = $signed({tx_i[lmp_pkg::POS_W-1], tx_i}) - $signed({cx_i[lmp_pkg::POS_W-1], cx_i});
  assign dy = $signed({ty_i[lmp_pkg::POS_W-1], ty_i}) - $signed({cy_i[lmp_pkg::POS_W-1], cy_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      negx_q <= dx[MAG_W-1];
      negy_q <= dy[MAG_W-1];
      magx_q <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      magy_q <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      feed_q <= feed_i;
      busy_q <= busy_i;
    end
  end

  always_comb begin
    rx  = PR_W'(magx_q) * PR_W'(spm_i) + PR_W'(128);
    ry  = PR_W'(magy_q) * PR_W'(spm_i) + PR_W'(128);
    nfx = rx[PR_W-1:8];
    nfy = ry[PR_W-1:8];
    zx  = (nfx == '0);
    zy  = (nfy == '0);
    item_d.nx    = (|nfx[NF_W-1:lmp_pkg::CNT_W]) ? '1 : nfx[lmp_pkg::CNT_W-1:0];
    item_d.ny    = (|nfy[NF_W-1:lmp_pkg::CNT_W]) ? '1 : nfy[lmp_pkg::CNT_W-1:0];
    item_d.dir_x = !negx_q || zx;
    item_d.dir_y = !negy_q || zy;
    item_d.p     = lmp_pkg::P_W'(feed_q) * lmp_pkg::P_W'(spm_i);
    if (busy_q) begin
      item_d.status = lmp_pkg::ST_BUSY;
    end else if (zx && zy) begin
      item_d.status = lmp_pkg::ST_NO_MOTION;
    end else begin
      item_d.status = lmp_pkg::ST_PLANNED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = vb_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

/* sv/lmp_fifo.sv */
// Two-entry queue of classified items between front and back end.
// Depends on lmp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lmp_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lmp_pkg::lmp_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lmp_pkg::lmp_item_t      out_item_o
);

  lmp_pkg::lmp_item_t mem_q [2];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  logic               push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item_i;
    end
  end

  `ASSERT_NEVER(a_cnt_range, cnt_q == 2'd3, "queue count out of range")
  `ASSERT_ALWAYS(a_ptr_gap, (cnt_q == 2'd1) == (wp_q != rp_q), "pointers disagree with count")

endmodule
`default_nettype wire

/* sv/lmp_back.sv */
// Back end: squares, pipelined square root, rate division and clamping.
// Depends on lmp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lmp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire lmp_pkg::lmp_item_t         in_item_i,
  input  wire logic [lmp_pkg::RATE_W-1:0] max_rate_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output lmp_pkg::lmp_res_t               out_res_o
);

  localparam int unsigned RS = lmp_pkg::ROOT_W;
  localparam int unsigned QS = lmp_pkg::QB;
  localparam int unsigned HI = lmp_pkg::NUM_W - QS;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // squares
  logic                     v0_q;
  lmp_pkg::lmp_item_t       it0_q;
  logic [lmp_pkg::SQ_W-1:0] sqx_q, sqy_q;
  logic [lmp_pkg::S_W-1:0]  s_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q <= in_item_i;
      sqx_q <= lmp_pkg::SQ_W'(in_item_i.nx) * lmp_pkg::SQ_W'(in_item_i.nx);
      sqy_q <= lmp_pkg::SQ_W'(in_item_i.ny) * lmp_pkg::SQ_W'(in_item_i.ny);
    end
  end
  assign s_sum = lmp_pkg::S_W'(sqx_q) + lmp_pkg::S_W'(sqy_q);

  // square root, two radicand bits per stage
  logic                        sv_q    [RS+1];
  lmp_pkg::lmp_item_t          sit_q   [RS+1];
  logic [lmp_pkg::RAD_W-1:0]   srad_q  [RS+1];
  logic [lmp_pkg::REM_W-1:0]   srem_q  [RS+1];
  logic [lmp_pkg::ROOT_W-1:0]  sroot_q [RS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en) sv_q[0] <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sit_q[0]   <= it0_q;
      srad_q[0]  <= {1'b0, s_sum, 14'd0};
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < RS; k++) begin : g_sqrt
    logic [lmp_pkg::REM_W-1:0] rem_sh, trial;
    logic                      ge;
    assign rem_sh = {srem_q[k][lmp_pkg::REM_W-3:0],
                     srad_q[k][lmp_pkg::RAD_W-1:lmp_pkg::RAD_W-2]};
    assign trial  = {sroot_q[k], 2'b01};
    assign ge     = (rem_sh >= trial);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else if (en) sv_q[k+1] <= sv_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sit_q[k+1]   <= sit_q[k];
        srad_q[k+1]  <= {srad_q[k][lmp_pkg::RAD_W-3:0], 2'b00};
        srem_q[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sroot_q[k+1] <= {sroot_q[k][lmp_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  // numerators n * P + D
  logic                       vm0_q, vm1_q;
  lmp_pkg::lmp_item_t         itm0_q, itm1_q;
  logic [lmp_pkg::ROOT_W-1:0] dm0_q, dm1_q;
  logic [lmp_pkg::PP_W-1:0]   pxl_q, pxh_q, pyl_q, pyh_q;
  logic [lmp_pkg::NP_W-1:0]   npx_q, npy_q;
  logic [lmp_pkg::NUM_W-1:0]  numx, numy;
  logic [lmp_pkg::P_W-1:0]    ps;

  assign ps = sit_q[RS].p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm0_q <= 1'b0;
      vm1_q <= 1'b0;
    end else if (en) begin
      vm0_q <= sv_q[RS];
      vm1_q <= vm0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      itm0_q <= sit_q[RS];
      dm0_q  <= sroot_q[RS];
      pxl_q  <= lmp_pkg::PP_W'(sit_q[RS].nx) * lmp_pkg::PP_W'(ps[lmp_pkg::PH_W-1:0]);
      pxh_q  <= lmp_pkg::PP_W'(sit_q[RS].nx) * lmp_pkg::PP_W'(ps[lmp_pkg::P_W-1:lmp_pkg::PH_W]);
      pyl_q  <= lmp_pkg::PP_W'(sit_q[RS].ny) * lmp_pkg::PP_W'(ps[lmp_pkg::PH_W-1:0]);
      pyh_q  <= lmp_pkg::PP_W'(sit_q[RS].ny) * lmp_pkg::PP_W'(ps[lmp_pkg::P_W-1:lmp_pkg::PH_W]);
      itm1_q <= itm0_q;
      dm1_q  <= dm0_q;
      npx_q  <= {pxh_q, lmp_pkg::PH_W'(0)} + lmp_pkg::NP_W'(pxl_q);
      npy_q  <= {pyh_q, lmp_pkg::PH_W'(0)} + lmp_pkg::NP_W'(pyl_q);
    end
  end
  assign numx = lmp_pkg::NUM_W'(npx_q) + lmp_pkg::NUM_W'(dm1_q);
  assign numy = lmp_pkg::NUM_W'(npy_q) + lmp_pkg::NUM_W'(dm1_q);

  // restoring division by 2D, one quotient bit per stage per axis
  logic                       dv_q  [QS+1];
  lmp_pkg::lmp_item_t         dit_q [QS+1];
  logic [lmp_pkg::ROOT_W-1:0] dd_q  [QS+1];
  logic [lmp_pkg::DIV_W-1:0]  rx_q  [QS+1];
  logic [lmp_pkg::DIV_W-1:0]  ry_q  [QS+1];
  logic [QS-1:0]              nx_q  [QS+1];
  logic [QS-1:0]              ny_q  [QS+1];
  logic [QS-1:0]              qx_q  [QS+1];
  logic [QS-1:0]              qy_q  [QS+1];
  logic                       ox_q  [QS+1];
  logic                       oy_q  [QS+1];
  logic [HI-1:0]              vd;
  logic                       ovx, ovy;

  assign vd  = HI'({dm1_q, 1'b0});
  assign ovx = (numx[lmp_pkg::NUM_W-1:QS] >= vd);
  assign ovy = (numy[lmp_pkg::NUM_W-1:QS] >= vd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (en) dv_q[0] <= vm1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dit_q[0] <= itm1_q;
      dd_q[0]  <= dm1_q;
      rx_q[0]  <= ovx ? '0 : lmp_pkg::DIV_W'(numx[lmp_pkg::NUM_W-1:QS]);
      ry_q[0]  <= ovy ? '0 : lmp_pkg::DIV_W'(numy[lmp_pkg::NUM_W-1:QS]);
      nx_q[0]  <= numx[QS-1:0];
      ny_q[0]  <= numy[QS-1:0];
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      ox_q[0]  <= ovx;
      oy_q[0]  <= ovy;
    end
  end

  for (genvar j = 0; j < QS; j++) begin : g_div
    logic [lmp_pkg::DIV_W-1:0] shx, shy, dvs;
    logic                      gex, gey;
    assign dvs = {1'b0, dd_q[j], 1'b0};
    assign shx = {rx_q[j][lmp_pkg::DIV_W-2:0], nx_q[j][QS-1]};
    assign shy = {ry_q[j][lmp_pkg::DIV_W-2:0], ny_q[j][QS-1]};
    assign gex = (shx >= dvs);
    assign gey = (shy >= dvs);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else if (en) dv_q[j+1] <= dv_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dit_q[j+1] <= dit_q[j];
        dd_q[j+1]  <= dd_q[j];
        rx_q[j+1]  <= gex ? shx - dvs : shx;
        ry_q[j+1]  <= gey ? shy - dvs : shy;
        nx_q[j+1]  <= {nx_q[j][QS-2:0], 1'b0};
        ny_q[j+1]  <= {ny_q[j][QS-2:0], 1'b0};
        qx_q[j+1]  <= {qx_q[j][QS-2:0], gex};
        qy_q[j+1]  <= {qy_q[j][QS-2:0], gey};
        ox_q[j+1]  <= ox_q[j];
        oy_q[j+1]  <= oy_q[j];
      end
    end
  end

  // clamp and output register
  lmp_pkg::lmp_item_t        fi;
  logic [lmp_pkg::FLR_W-1:0] qex, qey, flx, fly, mx, my, mr;
  logic                      ov_q, plan;
  lmp_pkg::lmp_res_t         res_q, res_d;

  assign fi   = dit_q[QS];
  assign plan = (fi.status == lmp_pkg::ST_PLANNED);

  always_comb begin
    qex = ox_q[QS] ? '1 : lmp_pkg::FLR_W'(qx_q[QS]);
    qey = oy_q[QS] ? '1 : lmp_pkg::FLR_W'(qy_q[QS]);
    flx = lmp_pkg::FLR_W'(fi.nx) * lmp_pkg::FLR_W'(lmp_pkg::MS_PER_S);
    fly = lmp_pkg::FLR_W'(fi.ny) * lmp_pkg::FLR_W'(lmp_pkg::MS_PER_S);
    mr  = lmp_pkg::FLR_W'(max_rate_i);
    mx  = (qex < flx) ? qex : flx;
    my  = (qey < fly) ? qey : fly;
    mx  = (mx < mr) ? mx : mr;
    my  = (my < mr) ? my : mr;
    res_d.status  = fi.status;
    res_d.x_steps = plan ? fi.nx : '0;
    res_d.y_steps = plan ? fi.ny : '0;
    res_d.dir_x   = plan && fi.dir_x;
    res_d.dir_y   = plan && fi.dir_y;
    res_d.x_rate  = plan ? mx[lmp_pkg::RATE_W-1:0] : '0;
    res_d.y_rate  = plan ? my[lmp_pkg::RATE_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= dv_q[QS];
  end
  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  `ASSERT_ALWAYS(a_rate_clamp,
                 !ov_q || ((res_q.x_rate <= max_rate_i) && (res_q.y_rate <= max_rate_i)),
                 "rate above clamp")
  `ASSERT_ALWAYS(a_idle_zero,
                 !ov_q || (res_q.status == lmp_pkg::ST_PLANNED) ||
                 ((res_q.x_steps == '0) && (res_q.x_rate == '0)),
                 "non planned beat carries data")
  `ASSERT_ALWAYS(a_plan_moves,
                 !ov_q || (res_q.status != lmp_pkg::ST_PLANNED) ||
                 (res_q.x_steps != '0) || (res_q.y_steps != '0),
                 "planned beat without steps")

endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking bench for two_axis_linear_move_planner_core: directed moves, then random moves
// under several register settings, each checked against a fixed or in-bench planner result.
// Depends on lmp_pkg and the planner RTL.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [23:0] tx;
    logic [23:0] ty;
    logic [23:0] cx;
    logic [23:0] cy;
    logic [23:0] feed;
    logic        busy;
  } move_t;

  typedef struct packed {
    move_t             mv;
    logic              typed;
    lmp_pkg::lmp_res_t res;
  } row_t;

  localparam lmp_pkg::lmp_res_t RES_BUSY =
    '{lmp_pkg::ST_BUSY, 24'd0, 24'd0, 1'b0, 1'b0, 20'd0, 20'd0};
  localparam lmp_pkg::lmp_res_t RES_STILL =
    '{lmp_pkg::ST_NO_MOTION, 24'd0, 24'd0, 1'b0, 1'b0, 20'd0, 20'd0};
  localparam lmp_pkg::lmp_res_t RES_NONE = '0;
  localparam logic [23:0] PMAX = 24'h7FFFFF;
  localparam logic [23:0] PMIN = 24'h800000;
  localparam int unsigned N_DIRECTED = 14;
  localparam int unsigned WD_LIMIT = 4000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_idx_i = 1'b0;
  logic [lmp_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [119:0]              s_axis_tdata = '0;
  logic                      s_axis_tuser = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [95:0]               m_axis_tdata;
  logic [1:0]                m_axis_tuser;

  two_axis_linear_move_planner_core u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0]       spm_cfg = lmp_pkg::SPM_RST;
  logic [19:0]       rate_cfg = lmp_pkg::MAX_RATE_RST;
  lmp_pkg::lmp_res_t plan_q[$];
  lmp_pkg::lmp_res_t offered_plan = '0;
  int unsigned       n_mismatch = 0;
  int unsigned       burst_left = 0;

  function automatic logic [23:0] axis_count(logic [23:0] tgt, logic [23:0] cur,
                                             output logic dir);
    longint      delta;
    logic [63:0] mag;
    logic [63:0] n;
    delta = longint'($signed(tgt)) - longint'($signed(cur));
    mag = (delta < 0) ? -delta : delta;
    n = (mag * 64'(spm_cfg) + 64'd128) >> 8;
    dir = (delta >= 0 || n == 0);
    return (n > 64'hFFFFFF) ? 24'hFFFFFF : n[23:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [67:0] r;
    logic [67:0] trial;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = r | (68'd1 << b);
      if (trial * trial <= {4'd0, v}) r = trial;
    end
    return r[63:0];
  endfunction

  function automatic logic [19:0] axis_rate(logic [23:0] n, logic [39:0] p, logic [63:0] d);
    logic [71:0] q;
    q = (72'(n) * 72'(p) + 72'(d)) / (72'd2 * 72'(d));
    if (q > 72'(n) * 72'd1000) q = 72'(n) * 72'd1000;
    if (q > 72'(rate_cfg)) q = 72'(rate_cfg);
    return q[19:0];
  endfunction

  function automatic lmp_pkg::lmp_res_t plan_move(move_t mv);
    lmp_pkg::lmp_res_t r;
    logic [63:0]       d;
    logic [39:0]       p;
    r = '0;
    if (mv.busy) return RES_BUSY;
    r.x_steps = axis_count(mv.tx, mv.cx, r.dir_x);
    r.y_steps = axis_count(mv.ty, mv.cy, r.dir_y);
    if (r.x_steps == 0 && r.y_steps == 0) return RES_STILL;
    d = root_floor((64'(r.x_steps) * 64'(r.x_steps) + 64'(r.y_steps) * 64'(r.y_steps)) << 14);
    p = 40'(spm_cfg) * 40'(mv.feed);
    r.status = lmp_pkg::ST_PLANNED;
    r.x_rate = axis_rate(r.x_steps, p, d);
    r.y_rate = axis_rate(r.y_steps, p, d);
    return r;
  endfunction

  function automatic move_t rand_move();
    move_t       mv;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    mv.cx = 24'($urandom);
    mv.cy = 24'($urandom);
    if (kind < 6) begin
      mv.tx = mv.cx + 24'($urandom_range(0, 8191)) - 24'd4096;
      mv.ty = mv.cy + 24'($urandom_range(0, 8191)) - 24'd4096;
    end else if (kind == 6) begin
      mv.tx = 24'($urandom);
      mv.ty = 24'($urandom);
    end else if (kind == 7) begin
      mv.tx = mv.cx;
      mv.ty = mv.cy;
    end else if (kind == 8) begin
      mv.tx = mv.cx + 24'($urandom_range(0, 4)) - 24'd2;
      mv.ty = mv.cy + 24'($urandom_range(0, 4)) - 24'd2;
    end else begin
      mv.tx = $urandom_range(0, 1) ? PMAX : PMIN;
      mv.ty = $urandom_range(0, 1) ? PMAX : PMIN;
      mv.cx = $urandom_range(0, 1) ? PMAX : PMIN;
      mv.cy = $urandom_range(0, 1) ? PMAX : PMIN;
    end
    case ($urandom_range(0, 19))
      0, 1:    mv.feed = '0;
      2:       mv.feed = 24'hFFFFFF;
      3, 4, 5: mv.feed = 24'($urandom);
      default: mv.feed = 24'($urandom_range(1, 65536));
    endcase
    mv.busy = ($urandom_range(0, 9) == 0);
    return mv;
  endfunction

  task automatic offer(move_t mv, lmp_pkg::lmp_res_t res);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mv.feed, mv.cy, mv.cx, mv.ty, mv.tx};
    s_axis_tuser  <= mv.busy;
    offered_plan  <= res;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(10, 60);
    end else begin
      burst_left--;
    end
  endtask

  task automatic set_regs(logic [15:0] spm, logic [19:0] max_rate);
    while (plan_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= lmp_pkg::CFG_SPM;
    cfg_data_i <= lmp_pkg::CFG_W'(spm);
    spm_cfg    <= spm;
    @(posedge clk_i);
    cfg_idx_i  <= lmp_pkg::CFG_MAX_RATE;
    cfg_data_i <= max_rate;
    rate_cfg   <= max_rate;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver: own stall pattern plus one long hold-off to back the pipeline up
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_cycle <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 2);
      if (rx_cycle >= 200 && rx_cycle < 800) m_axis_tready <= 1'b0;
      else if (rx_mode == 0) m_axis_tready <= 1'b1;
      else if (rx_mode == 1) m_axis_tready <= ($urandom_range(0, 9) < 7);
      else m_axis_tready <= ($urandom_range(0, 9) < 3);
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    lmp_pkg::lmp_res_t want;
    lmp_pkg::lmp_res_t got;
    if (s_axis_tvalid && s_axis_tready) plan_q.push_back(offered_plan);
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{lmp_pkg::lmp_status_e'(m_axis_tuser), m_axis_tdata[23:0], m_axis_tdata[47:24],
              m_axis_tdata[48], m_axis_tdata[49], m_axis_tdata[69:50], m_axis_tdata[89:70]};
      if (plan_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = plan_q.pop_front();
        if (got.status !== want.status || got.x_steps !== want.x_steps ||
            got.y_steps !== want.y_steps || got.dir_x !== want.dir_x ||
            got.dir_y !== want.dir_y || got.x_rate !== want.x_rate ||
            got.y_rate !== want.y_rate) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: exp %p got %p", want, got);
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  row_t directed[N_DIRECTED];
  logic [15:0] phase_spm[6]  = '{16'd1, 16'd65535, 16'd0, 16'd300, 16'd12, 16'd100};
  logic [19:0] phase_rate[6] = '{20'd1, 20'd1000000, 20'd500, 20'd0, 20'hFFFFF, 20'd20000};

  initial begin
    move_t mv;
    directed = '{
      '{'{PMAX, PMAX, PMIN, PMIN, 24'hFFFFFF, 1'b1}, 1'b1, RES_BUSY},
      '{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1}, 1'b1, RES_BUSY},
      '{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd1000, 1'b0}, 1'b1, RES_STILL},
      '{'{24'd1, 24'd1, 24'd0, 24'd0, 24'd1000, 1'b0}, 1'b1, RES_STILL},
      '{'{24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd1000, 1'b0}, 1'b1, RES_STILL},
      '{'{PMAX, 24'd5, PMIN, 24'd5, 24'hFFFFFF, 1'b0}, 1'b0, RES_NONE},
      '{'{PMIN, 24'd5, PMAX, 24'd5, 24'd256, 1'b0}, 1'b0, RES_NONE},
      '{'{24'd0, PMAX, 24'd0, PMIN, 24'd1, 1'b0}, 1'b0, RES_NONE},
      '{'{PMIN, PMIN, PMAX, PMAX, 24'd25600, 1'b0}, 1'b0, RES_NONE},
      '{'{24'hFFFFFF, 24'd256, 24'd0, 24'd0, 24'd2560, 1'b0}, 1'b0, RES_NONE},
      '{'{24'd2560, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0}, 1'b0, RES_NONE},
      '{'{24'd1000, 24'd1000, 24'd0, 24'd0, 24'd25600, 1'b0}, 1'b0, RES_NONE},
      '{'{24'd2, 24'hFFFFFE, 24'd0, 24'd0, 24'hFFFFFF, 1'b0}, 1'b0, RES_NONE},
      '{'{24'd100, 24'd0, 24'd0, 24'd7, 24'd77, 1'b0}, 1'b0, RES_NONE}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < N_DIRECTED; i++)
      offer(directed[i].mv, directed[i].typed ? directed[i].res : plan_move(directed[i].mv));
    for (int k = 0; k < 300; k++) begin
      mv = rand_move();
      offer(mv, plan_move(mv));
    end
    s_axis_tvalid <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(phase_spm[ph], phase_rate[ph]);
      for (int k = 0; k < 135; k++) begin
        mv = rand_move();
        offer(mv, plan_move(mv));
      end
      s_axis_tvalid <= 1'b0;
    end
    while (plan_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_mismatch == 0 && plan_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
